// ===== sv/sitda_pkg.sv =====
// Shared constants for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps

package sitda_pkg;

	localparam int ValueWidth = 32;
	localparam int NumDigits = 10;
	localparam int DigitWidth = 4;
	localparam int BcdWidth = NumDigits * DigitWidth;
	localparam int CountWidth = $clog2(ValueWidth);
	localparam int CharWidth = 6;
	localparam int LengthWidth = 4;

	localparam logic [CharWidth-1:0] CharZero = 6'd48;
	localparam logic [CharWidth-1:0] CharMinus = 6'd45;
	localparam logic [DigitWidth-1:0] AdjustLimit = 4'd5;
	localparam logic [DigitWidth-1:0] AdjustAdd = 4'd3;

endpackage

// ===== sv/sitda_bcd_conv.sv =====
// Bit-serial binary to BCD converter using one shift-and-add-three step per cycle.
`timescale 1ns / 1ps

module sitda_bcd_conv (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [sitda_pkg::ValueWidth-1:0]      mag,
	output logic                                  done,
	output logic [sitda_pkg::BcdWidth-1:0]        bcd
);

	logic                                 run_q;
	logic                                 done_q;
	logic [sitda_pkg::CountWidth-1:0]     cnt_q;
	logic [sitda_pkg::ValueWidth-1:0]     shift_q;
	logic [sitda_pkg::BcdWidth-1:0]       bcd_q;
	logic [sitda_pkg::BcdWidth-1:0]       bcd_adj;

	always_comb begin
		logic [sitda_pkg::DigitWidth-1:0] d;
		bcd_adj = bcd_q;
		for (int i = 0; i < sitda_pkg::NumDigits; i++) begin
			d = bcd_q[i*sitda_pkg::DigitWidth +: sitda_pkg::DigitWidth];
			if (d >= sitda_pkg::AdjustLimit) begin
				bcd_adj[i*sitda_pkg::DigitWidth +: sitda_pkg::DigitWidth] =
					d + sitda_pkg::AdjustAdd;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '1;
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - sitda_pkg::CountWidth'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= mag;
			bcd_q   <= '0;
		end else if (run_q) begin
			shift_q <= {shift_q[sitda_pkg::ValueWidth-2:0], 1'b0};
			bcd_q   <= {bcd_adj[sitda_pkg::BcdWidth-2:0], shift_q[sitda_pkg::ValueWidth-1]};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

// ===== sv/signed_int_to_decimal_ascii.sv =====
// Top level: signed 32-bit integer to decimal ASCII text, one character per strobe.
`timescale 1ns / 1ps

// An item is taken when start is high and busy is low. Its magnitude goes through
// a bit-serial BCD converter that shifts one bit per cycle; when it is done, the text
// is sized. The characters then leave one per cycle, most significant first, each
// shown for exactly one cycle with strobe high; the receiver cannot stall and must
// take every character as it appears. The time from acceptance to the last character
// is set by the conversion loop and the text length. Busy stays high until the last
// character has been launched.

module signed_int_to_decimal_ascii (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [sitda_pkg::ValueWidth-1:0] value,
	output logic                                   strobe,
	output logic [sitda_pkg::CharWidth-1:0]        character,
	output logic                                   is_last,
	output logic [sitda_pkg::LengthWidth-1:0]      text_length
);

	typedef enum logic [2:0] {
		StIdle = 3'b001,
		StConv = 3'b010,
		StEmit = 3'b100
	} state_t;

	state_t                                  state_q;
	logic                                    accept;
	logic                                    conv_done;
	logic [sitda_pkg::ValueWidth-1:0]        mag;
	logic [sitda_pkg::BcdWidth-1:0]          bcd;
	logic [sitda_pkg::DigitWidth-1:0]        digits [sitda_pkg::NumDigits];
	logic [sitda_pkg::LengthWidth-1:0]       ndig;
	logic                                    minus_q;
	logic [sitda_pkg::LengthWidth-1:0]       idx_q;
	logic [sitda_pkg::LengthWidth-1:0]       len_q;
	logic                                    strobe_q;
	logic [sitda_pkg::CharWidth-1:0]         character_q;
	logic                                    is_last_q;
	logic [sitda_pkg::LengthWidth-1:0]       text_length_q;

	assign busy   = (state_q != StIdle);
	assign accept = start && !busy;
	assign mag    = value[sitda_pkg::ValueWidth-1] ?
		(32'd0 - $unsigned(value)) : $unsigned(value);

	sitda_bcd_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.mag    (mag),
		.done   (conv_done),
		.bcd    (bcd)
	);

	always_comb begin
		ndig = 4'd1;
		for (int i = 0; i < sitda_pkg::NumDigits; i++) begin
			digits[i] = bcd[i*sitda_pkg::DigitWidth +: sitda_pkg::DigitWidth];
			if (digits[i] != '0) begin
				ndig = 4'(i + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= StIdle;
			strobe_q <= 1'b0;
			minus_q  <= 1'b0;
			idx_q    <= '0;
			len_q    <= '0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				StIdle: begin
					if (start) begin
						minus_q <= value[sitda_pkg::ValueWidth-1];
						state_q <= StConv;
					end
				end
				StConv: begin
					if (conv_done) begin
						idx_q   <= ndig - 4'd1;
						len_q   <= ndig + {3'd0, minus_q};
						state_q <= StEmit;
					end
				end
				StEmit: begin
					strobe_q <= 1'b1;
					if (minus_q) begin
						minus_q <= 1'b0;
					end else if (idx_q == '0) begin
						state_q <= StIdle;
					end else begin
						idx_q <= idx_q - 4'd1;
					end
				end
				default: begin
					state_q <= StIdle;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == StEmit) begin
			text_length_q <= len_q;
			if (minus_q) begin
				character_q <= sitda_pkg::CharMinus;
				is_last_q   <= 1'b0;
			end else begin
				character_q <= sitda_pkg::CharZero + {2'b00, digits[idx_q]};
				is_last_q   <= (idx_q == '0);
			end
		end
	end

	assign strobe      = strobe_q;
	assign character   = character_q;
	assign is_last     = is_last_q;
	assign text_length = text_length_q;

endmodule
